// File: hw/rtl/cbts_pkg.sv
// Shared types, codes and defaults for the cassette block tape store.
package cbts_pkg;

    localparam int CBTS_MAX_BLOCKS = 64;
    localparam int CBTS_TAPE_BYTES = 65536;

    localparam logic [2:0] OP_OPEN_READ   = 3'd0;
    localparam logic [2:0] OP_READ_BYTE   = 3'd1;
    localparam logic [2:0] OP_CLOSE_READ  = 3'd2;
    localparam logic [2:0] OP_OPEN_WRITE  = 3'd3;
    localparam logic [2:0] OP_WRITE_BYTE  = 3'd4;
    localparam logic [2:0] OP_CLOSE_WRITE = 3'd5;
    localparam logic [2:0] OP_REWIND      = 3'd6;
    localparam logic [2:0] OP_ERASE       = 3'd7;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    localparam logic [1:0] CARRY_KEEP  = 2'd0;
    localparam logic [1:0] CARRY_CLEAR = 2'd1;
    localparam logic [1:0] CARRY_SET   = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] write_byte;
    } cbts_cmd_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic [1:0] carry_action;
        logic       motor_on;
    } cbts_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic exec;
        logic load_direct;
        logic load_held;
    } cbts_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic read_hit;
        logic out_free;
    } cbts_sts_t;

endpackage

// File: hw/rtl/cbts_chan_if.sv
// Valid/ready channel interface carrying one word of a given payload type.
interface cbts_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/cbts_ctrl.sv
// Sequencing state machine for the cassette block tape store.
module cbts_ctrl
    import cbts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cbts_sts_t sts,
    output cbts_ctl_t ctl
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_DELIV = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ctl             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.take   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                // A result with no tape byte goes straight to the output
                // register when it is free.
                if (!sts.read_hit && sts.out_free)
                begin
                    ctl.load_direct = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DELIV;
                end
            end
            ST_DELIV:
            begin
                if (sts.out_free)
                begin
                    ctl.load_held = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/cbts_dp.sv
// Datapath: tape position registers, block tables, byte store and output register.
module cbts_dp
    import cbts_pkg::*;
#(
    parameter int MAX_BLOCKS = CBTS_MAX_BLOCKS,
    parameter int TAPE_BYTES = CBTS_TAPE_BYTES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cbts_ctl_t ctl,
    output cbts_sts_t sts,
    input  cbts_cmd_t cmd_word,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output cbts_rsp_t rsp_word
);

    localparam int BW    = $clog2(MAX_BLOCKS + 1);
    localparam int IW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(TAPE_BYTES + 1);
    localparam int AW    = $clog2(TAPE_BYTES);

    localparam logic [BW-1:0]    MAXB  = BW'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] TAPEB = CNT_W'(TAPE_BYTES);

    // Position and fill state.
    logic [1:0]       mode_reg, mode_next;
    logic             motor_reg, motor_next;
    logic [BW-1:0]    cur_blk_reg, cur_blk_next;
    logic [CNT_W-1:0] cur_off_reg, cur_off_next;
    logic [BW-1:0]    blk_cnt_reg, blk_cnt_next;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;

    cbts_cmd_t cmd_reg;

    // Block tables and byte store.
    logic [CNT_W-1:0] start_mem [MAX_BLOCKS];
    logic [CNT_W-1:0] len_mem   [MAX_BLOCKS];
    logic [7:0]       tape_mem  [TAPE_BYTES];
    logic [CNT_W-1:0] start_q;
    logic [CNT_W-1:0] len_q;
    logic [7:0]       byte_q;

    logic             start_we;
    logic             len_we;
    logic [IW-1:0]    len_wa;
    logic [CNT_W-1:0] len_wd;
    logic             tape_we;

    // Held result of the command under way.
    logic [1:0] res_carry_reg;
    logic       res_motor_reg;
    logic       res_valid_reg;
    logic       res_aok_reg;

    logic             out_valid_reg;
    cbts_rsp_t        out_reg;

    logic [BW-1:0]    blk_adv;
    logic             rd_hit;
    logic             wr_ok;
    logic [CNT_W:0]   rd_addr;
    logic             addr_ok;
    logic [1:0]       carry_next;
    cbts_rsp_t        direct_word;
    cbts_rsp_t        held_word;

    assign blk_adv = (mode_reg == MODE_READ && cur_blk_reg < MAXB) ?
                     cur_blk_reg + BW'(1) : cur_blk_reg;

    assign rd_hit = (cmd_reg.operation == OP_READ_BYTE) && (mode_reg == MODE_READ) &&
                    (cur_blk_reg < blk_cnt_reg) && (cur_off_reg < len_q);
    assign wr_ok  = (cmd_reg.operation == OP_WRITE_BYTE) && (mode_reg == MODE_WRITE) &&
                    (cur_blk_reg < blk_cnt_reg) && (byte_cnt_reg < TAPEB);

    assign rd_addr = {1'b0, start_q} + {1'b0, cur_off_reg};
    assign addr_ok = rd_addr < (CNT_W + 1)'(TAPE_BYTES);

    always_comb
    begin
        mode_next     = mode_reg;
        motor_next    = motor_reg;
        cur_blk_next  = cur_blk_reg;
        cur_off_next  = cur_off_reg;
        blk_cnt_next  = blk_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        carry_next    = CARRY_KEEP;
        start_we      = 1'b0;
        len_we        = 1'b0;
        len_wa        = blk_cnt_reg[IW-1:0];
        len_wd        = '0;
        tape_we       = 1'b0;
        unique case (cmd_reg.operation)
            OP_OPEN_READ:
            begin
                cur_blk_next = blk_adv;
                cur_off_next = '0;
                if (mode_reg == MODE_WRITE || blk_adv >= blk_cnt_reg)
                begin
                    mode_next  = MODE_IDLE;
                    motor_next = 1'b0;
                    carry_next = CARRY_SET;
                end
                else
                begin
                    mode_next  = MODE_READ;
                    motor_next = 1'b1;
                    carry_next = CARRY_CLEAR;
                end
            end
            OP_READ_BYTE:
            begin
                if (rd_hit)
                begin
                    cur_off_next = cur_off_reg + CNT_W'(1);
                    carry_next   = CARRY_CLEAR;
                end
                else
                begin
                    carry_next = CARRY_SET;
                end
            end
            OP_CLOSE_READ:
            begin
                cur_blk_next = blk_adv;
                mode_next    = MODE_IDLE;
                cur_off_next = '0;
                motor_next   = 1'b0;
            end
            OP_OPEN_WRITE:
            begin
                cur_off_next = '0;
                cur_blk_next = blk_cnt_reg;
                if (blk_cnt_reg >= MAXB)
                begin
                    mode_next  = MODE_IDLE;
                    motor_next = 1'b0;
                    carry_next = CARRY_SET;
                end
                else
                begin
                    start_we     = 1'b1;
                    len_we       = 1'b1;
                    blk_cnt_next = blk_cnt_reg + BW'(1);
                    mode_next    = MODE_WRITE;
                    motor_next   = 1'b1;
                    carry_next   = CARRY_CLEAR;
                end
            end
            OP_WRITE_BYTE:
            begin
                if (wr_ok)
                begin
                    // While writing, the open block's length equals the offset.
                    tape_we       = 1'b1;
                    len_we        = 1'b1;
                    len_wa        = cur_blk_reg[IW-1:0];
                    len_wd        = cur_off_reg + CNT_W'(1);
                    byte_cnt_next = byte_cnt_reg + CNT_W'(1);
                    cur_off_next  = cur_off_reg + CNT_W'(1);
                    carry_next    = CARRY_CLEAR;
                end
                else
                begin
                    carry_next = CARRY_SET;
                end
            end
            OP_CLOSE_WRITE:
            begin
                mode_next    = MODE_IDLE;
                cur_blk_next = blk_cnt_reg;
                cur_off_next = '0;
                motor_next   = 1'b0;
            end
            OP_REWIND:
            begin
                mode_next    = MODE_IDLE;
                cur_blk_next = '0;
                cur_off_next = '0;
            end
            OP_ERASE:
            begin
                mode_next     = MODE_IDLE;
                cur_blk_next  = '0;
                cur_off_next  = '0;
                blk_cnt_next  = '0;
                byte_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            motor_reg    <= 1'b0;
            cur_blk_reg  <= '0;
            cur_off_reg  <= '0;
            blk_cnt_reg  <= '0;
            byte_cnt_reg <= '0;
        end
        else if (ctl.exec)
        begin
            mode_reg     <= mode_next;
            motor_reg    <= motor_next;
            cur_blk_reg  <= cur_blk_next;
            cur_off_reg  <= cur_off_next;
            blk_cnt_reg  <= blk_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            cmd_reg <= cmd_word;
        end
        if (ctl.exec)
        begin
            res_carry_reg <= carry_next;
            res_motor_reg <= motor_next;
            res_valid_reg <= rd_hit;
            res_aok_reg   <= addr_ok;
        end
    end

    // Block tables: read at the current block while waiting for a command.
    always_ff @(posedge clk)
    begin
        if (ctl.exec && start_we)
        begin
            start_mem[blk_cnt_reg[IW-1:0]] <= byte_cnt_reg;
        end
        start_q <= start_mem[cur_blk_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && len_we)
        begin
            len_mem[len_wa] <= len_wd;
        end
        len_q <= len_mem[cur_blk_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && tape_we)
        begin
            tape_mem[byte_cnt_reg[AW-1:0]] <= cmd_reg.write_byte;
        end
        if (ctl.exec && rd_hit && addr_ok)
        begin
            byte_q <= tape_mem[rd_addr[AW-1:0]];
        end
    end

    always_comb
    begin
        direct_word              = '0;
        direct_word.carry_action = carry_next;
        direct_word.motor_on     = motor_next;

        held_word              = '0;
        held_word.read_byte    = (res_valid_reg && res_aok_reg) ? byte_q : 8'd0;
        held_word.read_valid   = res_valid_reg;
        held_word.carry_action = res_carry_reg;
        held_word.motor_on     = res_motor_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_direct || ctl.load_held)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_direct)
        begin
            out_reg <= direct_word;
        end
        else if (ctl.load_held)
        begin
            out_reg <= held_word;
        end
    end

    assign sts.read_hit = rd_hit;
    assign sts.out_free = !out_valid_reg || rsp_ready;
    assign rsp_valid    = out_valid_reg;
    assign rsp_word     = out_reg;

endmodule

// File: hw/rtl/cassette_block_tape_store.sv
// Top level of the cassette block tape store: controller, datapath and channel ports.
//
//  Channel | Direction | Payload                                          | Handshake
//  --------+-----------+--------------------------------------------------+------------
//  cmd     | in        | operation, write_byte                            | valid/ready
//  rsp     | out       | read_byte, read_valid, carry_action, motor_on    | valid/ready
//
// One command at a time, one result word each. A result with no tape byte goes
// from the execute state into the output register; a read byte hit is held in
// the delivery state with the byte read from memory. The next command is taken
// back in idle. A result that finds the output register occupied waits inside,
// and the command input stalls meanwhile. Asynchronous active-low reset clears
// the controller state, output valid, mode, position, counts and motor only.
module cassette_block_tape_store
    import cbts_pkg::*;
#(
    parameter int MAX_BLOCKS = CBTS_MAX_BLOCKS,
    parameter int TAPE_BYTES = CBTS_TAPE_BYTES
)
(
    input  logic            clk,
    input  logic            rst_n,
    cbts_chan_if.sink       cmd,
    cbts_chan_if.source     rsp
);

    cbts_ctl_t ctl;
    cbts_sts_t sts;
    cbts_cmd_t cmd_word;
    cbts_rsp_t rsp_word;
    logic      cmd_ready;
    logic      rsp_valid;

    assign cmd_word    = cmd.payload;
    assign cmd.ready   = cmd_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_word;

    // The controller steps each command through acceptance, execution and any delivery.
    cbts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // The datapath owns the tape state, the block tables, the byte memory and
    // the output register.
    cbts_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .TAPE_BYTES (TAPE_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .rsp_word  (rsp_word)
    );

endmodule

// File: tb/cbts_tape_checker.sv
`timescale 1ns / 1ps
// Passive checker for the cassette block tape store: tracks tape state and scores every result word.
module cbts_tape_checker
    import cbts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cbts_chan_if  cmd,
    cbts_chan_if  rsp,
    output int    mismatches,
    output int    outstanding
);

    // Tape state as the block should hold it.
    logic [1:0]  tape_mode;
    logic [6:0]  cur_block;
    logic [6:0]  blocks_used;
    logic [16:0] cur_offset;
    logic [16:0] bytes_used;
    logic        motor;
    logic [16:0] block_start [CBTS_MAX_BLOCKS];
    logic [16:0] block_len [CBTS_MAX_BLOCKS];
    logic [7:0]  tape_bytes [CBTS_TAPE_BYTES];

    cbts_rsp_t   due_results [$];
    cbts_rsp_t   got;
    cbts_rsp_t   want;
    int          results_seen;

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        results_seen = 0;
    end

    task automatic report(string field, int got_val, int want_val);
        $display("%0t: result word %0d, %s is %0h, %0h was due",
                 $realtime, results_seen, field, got_val, want_val);
        mismatches++;
    endtask

    // Applies one command to the tape state and returns the word it must produce.
    function automatic cbts_rsp_t run_tape_command(cbts_cmd_t c);
        cbts_rsp_t   r;
        logic [17:0] addr;
        r = '0;
        r.carry_action = CARRY_KEEP;
        case (c.operation)
            OP_OPEN_READ: begin
                if (tape_mode == MODE_READ && cur_block < CBTS_MAX_BLOCKS)
                    cur_block++;
                cur_offset = '0;
                if (tape_mode == MODE_WRITE || cur_block >= blocks_used) begin
                    tape_mode      = MODE_IDLE;
                    motor          = 1'b0;
                    r.carry_action = CARRY_SET;
                end
                else begin
                    tape_mode      = MODE_READ;
                    motor          = 1'b1;
                    r.carry_action = CARRY_CLEAR;
                end
            end
            OP_READ_BYTE: begin
                if (tape_mode != MODE_READ || cur_block >= blocks_used
                    || cur_block >= CBTS_MAX_BLOCKS
                    || cur_offset >= block_len[cur_block]) begin
                    r.carry_action = CARRY_SET;
                end
                else begin
                    addr = {1'b0, block_start[cur_block]} + cur_offset;
                    if (addr < CBTS_TAPE_BYTES)
                        r.read_byte = tape_bytes[addr[15:0]];
                    r.read_valid   = 1'b1;
                    cur_offset++;
                    r.carry_action = CARRY_CLEAR;
                end
            end
            OP_CLOSE_READ: begin
                if (tape_mode == MODE_READ && cur_block < CBTS_MAX_BLOCKS)
                    cur_block++;
                tape_mode  = MODE_IDLE;
                cur_offset = '0;
                motor      = 1'b0;
            end
            OP_OPEN_WRITE: begin
                cur_offset = '0;
                if (blocks_used >= CBTS_MAX_BLOCKS) begin
                    cur_block      = blocks_used;
                    tape_mode      = MODE_IDLE;
                    motor          = 1'b0;
                    r.carry_action = CARRY_SET;
                end
                else begin
                    block_start[blocks_used] = bytes_used;
                    block_len[blocks_used]   = '0;
                    cur_block      = blocks_used;
                    blocks_used++;
                    tape_mode      = MODE_WRITE;
                    motor          = 1'b1;
                    r.carry_action = CARRY_CLEAR;
                end
            end
            OP_WRITE_BYTE: begin
                if (tape_mode != MODE_WRITE || cur_block >= blocks_used
                    || cur_block >= CBTS_MAX_BLOCKS
                    || bytes_used >= CBTS_TAPE_BYTES) begin
                    r.carry_action = CARRY_SET;
                end
                else begin
                    tape_bytes[bytes_used[15:0]] = c.write_byte;
                    bytes_used++;
                    block_len[cur_block]++;
                    cur_offset++;
                    r.carry_action = CARRY_CLEAR;
                end
            end
            OP_CLOSE_WRITE: begin
                tape_mode  = MODE_IDLE;
                cur_block  = blocks_used;
                cur_offset = '0;
                motor      = 1'b0;
            end
            OP_REWIND: begin
                tape_mode  = MODE_IDLE;
                cur_block  = '0;
                cur_offset = '0;
            end
            OP_ERASE: begin
                tape_mode   = MODE_IDLE;
                cur_block   = '0;
                cur_offset  = '0;
                blocks_used = '0;
                bytes_used  = '0;
            end
            default: ;
        endcase
        r.motor_on = motor;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tape_mode   = MODE_IDLE;
            cur_block   = '0;
            cur_offset  = '0;
            blocks_used = '0;
            bytes_used  = '0;
            motor       = 1'b0;
            due_results.delete();
            outstanding <= 0;
        end
        else begin
            if (cmd.valid && cmd.ready)
                due_results.push_back(run_tape_command(cmd.payload));
            if (rsp.valid && rsp.ready) begin
                got = rsp.payload;
                if (due_results.size() == 0) begin
                    report("word with nothing due", got, 0);
                end
                else begin
                    want = due_results.pop_front();
                    if (got.read_byte !== want.read_byte)
                        report("read_byte", got.read_byte, want.read_byte);
                    if (got.read_valid !== want.read_valid)
                        report("read_valid", got.read_valid, want.read_valid);
                    if (got.carry_action !== want.carry_action)
                        report("carry_action", got.carry_action, want.carry_action);
                    if (got.motor_on !== want.motor_on)
                        report("motor_on", got.motor_on, want.motor_on);
                end
                results_seen++;
            end
            outstanding <= due_results.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the tape store testbench: clock, reset, command stimulus, consumer stalls and verdict.
module tb;
    import cbts_pkg::*;

    // The longest quiet stretch in a correct run is the deliberate consumer
    // hold-off (HOLD_CYCLES) plus a long sender gap and the block's own delay.
    // The watchdog limit is several times that.
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 300;
    localparam int FILL_BLOCK   = 2;

    logic clk = 1'b0;
    logic rst_n;

    cbts_chan_if #(.payload_t(cbts_cmd_t)) cmd_ch ();
    cbts_chan_if #(.payload_t(cbts_rsp_t)) rsp_ch ();

    int   mismatches;
    int   outstanding;
    int   words_sent = 0;
    int   idle_cycles = 0;

    // Steady flags switch off all idling on one side for a stretch.
    bit   tx_steady = 1'b0;
    bit   rx_steady = 1'b0;

    // The stimulus asks for a long consumer hold-off by bumping the request
    // count; the consumer process serves each request once.
    int   hold_requests = 0;
    int   holds_served = 0;

    cassette_block_tape_store u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    cbts_tape_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one command word and returns at the edge where it is taken. Valid
    // stays high into the next word unless a gap is drawn.
    task automatic send(logic [2:0] op, logic [7:0] data);
        cbts_cmd_t w;
        int        gap;
        w.operation  = op;
        w.write_byte = data;
        gap = tx_steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= w;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        words_sent++;
    endtask

    // Any command other than a byte write; the data field still carries noise.
    task automatic send_op(logic [2:0] op);
        send(op, 8'($urandom));
    endtask

    // Consumer side: random ready with gaps, steady stretches, and the long
    // hold-off that lets the block fill up and push back on the command side.
    initial
    begin
        int gap;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_served != hold_requests)
            begin
                holds_served++;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_steady)
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                gap = idle_gap();
                if (gap > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // Watchdog: a run in which no word moves on either channel for too long
    // has hung, whether in the block or with results left undelivered.
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (cmd_ch.valid && cmd_ch.ready)
            || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int stop_at;
        int pick;
        int count;
        rst_n          <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Reads, writes and closes on an empty tape first: reads and
        // writes outside their mode set the carry, the closes only stop the
        // motor.
        send_op(OP_READ_BYTE);
        send_op(OP_OPEN_READ);
        send(OP_WRITE_BYTE, 8'hFF);
        send_op(OP_CLOSE_READ);
        send_op(OP_CLOSE_WRITE);
        // Block 0 with the byte extremes, then an open read while writing,
        // which is refused.
        send_op(OP_OPEN_WRITE);
        send(OP_WRITE_BYTE, 8'h00);
        send(OP_WRITE_BYTE, 8'hFF);
        send(OP_WRITE_BYTE, 8'hA5);
        send_op(OP_OPEN_READ);
        // Block 1 with a single byte, and an empty block 2.
        send_op(OP_OPEN_WRITE);
        send(OP_WRITE_BYTE, 8'h5A);
        send_op(OP_OPEN_WRITE);
        send_op(OP_CLOSE_WRITE);
        // Read back: all of block 0 and one read past its end, then an open
        // read while reading steps to block 1, then to the empty block 2,
        // and once more beyond the last stored block.
        send_op(OP_REWIND);
        send_op(OP_OPEN_READ);
        repeat (4) send_op(OP_READ_BYTE);
        send_op(OP_OPEN_READ);
        repeat (2) send_op(OP_READ_BYTE);
        send_op(OP_OPEN_READ);
        send_op(OP_READ_BYTE);
        send_op(OP_OPEN_READ);
        // Close read while reading also steps to the next block.
        send_op(OP_REWIND);
        send_op(OP_OPEN_READ);
        send_op(OP_CLOSE_READ);
        send_op(OP_OPEN_READ);
        send_op(OP_READ_BYTE);
        // Erase leaves nothing to open.
        send_op(OP_ERASE);
        send_op(OP_OPEN_READ);

        // Fill the whole block table: every block slot gets a short block of
        // FILL_BLOCK bytes. Both sides run without idling here to keep the
        // run short.
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int blk = 0; blk < CBTS_MAX_BLOCKS; blk++)
        begin
            send_op(OP_OPEN_WRITE);
            for (int i = 0; i < FILL_BLOCK; i++)
                send(OP_WRITE_BYTE, 8'($urandom));
            if (blk < CBTS_MAX_BLOCKS - 1)
                send_op(OP_CLOSE_WRITE);
        end
        // Block table full: open write appends nothing and parks the tape
        // past the last block.
        send_op(OP_OPEN_WRITE);
        send(OP_WRITE_BYTE, 8'($urandom));
        send_op(OP_CLOSE_WRITE);
        send_op(OP_OPEN_READ);
        // Walk the whole tape with open reads, sampling the head of each
        // block, then read out the last block completely and one past it.
        send_op(OP_REWIND);
        send_op(OP_OPEN_READ);
        for (int blk = 0; blk < CBTS_MAX_BLOCKS; blk++)
        begin
            if (blk > 0)
                send_op(OP_OPEN_READ);
            count = (blk == CBTS_MAX_BLOCKS - 1) ? FILL_BLOCK + 1 : 3;
            repeat (count) send_op(OP_READ_BYTE);
        end
        // The block number stops at the table size instead of wrapping.
        send_op(OP_OPEN_READ);
        send_op(OP_READ_BYTE);
        send_op(OP_CLOSE_READ);
        send_op(OP_ERASE);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Random part: mostly well-formed write and read sessions with random
        // contents and lengths, plus noise commands and the odd erase.
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at)
        begin
            // Two long consumer hold-offs while commands keep coming.
            if (hold_requests == 0 && words_sent > stop_at - 250)
                hold_requests++;
            if (hold_requests == 1 && words_sent > stop_at - 80)
                hold_requests++;
            if ($urandom_range(0, 9) == 0)
                tx_steady = ~tx_steady;
            if ($urandom_range(0, 9) == 0)
                rx_steady = ~rx_steady;

            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_op(OP_OPEN_WRITE);
                count = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 8);
                repeat (count) send(OP_WRITE_BYTE, 8'($urandom));
                if ($urandom_range(0, 9) != 0)
                    send_op(OP_CLOSE_WRITE);
            end
            else if (pick < 72)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_op(OP_REWIND);
                send_op(OP_OPEN_READ);
                repeat ($urandom_range(0, 10)) send_op(OP_READ_BYTE);
                if ($urandom_range(0, 1) == 0)
                begin
                    send_op(OP_OPEN_READ);
                    repeat ($urandom_range(0, 6)) send_op(OP_READ_BYTE);
                end
                if ($urandom_range(0, 3) != 0)
                    send_op(OP_CLOSE_READ);
            end
            else if (pick < 97)
            begin
                send(3'($urandom_range(OP_OPEN_READ, OP_REWIND)), 8'($urandom));
            end
            else
            begin
                send_op(OP_ERASE);
            end
        end

        // Drain: wait for every due result, then keep watching the result channel in
        // case the block produces a word nobody asked for.
        cmd_ch.valid <= 1'b0;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
